/* rtl/core/arp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp package
// shared types and codes for the arp cache controller and datapath
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_REFRESH = 3'd2;
    localparam logic [2:0] ST_REPLY   = 3'd3;
    localparam logic [2:0] ST_LEARNED = 3'd4;
    localparam logic [2:0] ST_IGNORED = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_LEARN  = 2'd1;
    localparam logic [1:0] REQ_STATIC = 2'd2;
    localparam logic [1:0] REQ_RX     = 2'd3;

    localparam logic [1:0] CFG_OWN_IP  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_REFRESH = 2'd2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;
    localparam logic [15:0] MIN_FRAME   = 16'd28;

    // controller to datapath
    typedef struct packed {
        logic start;   // capture request, reset scan
        logic step;    // advance scan pointer
        logic finish;  // apply table update and load result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_stat;

endpackage

/* rtl/core/arp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp controller
// sequences capture, table scan, update and result handoff
// ----------------------------------------------------------------------------
module arp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_fire,
    input  logic           i_out_free,
    input  arp_pkg::t_stat i_stat,
    output arp_pkg::t_cmd  o_cmd,
    output logic           o_in_ready
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_req_fire) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to empty
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* rtl/core/arp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp datapath
// request registers, entry table, scan pointer, age test and result logic
// ----------------------------------------------------------------------------
module arp_dp #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  arp_pkg::t_cmd i_cmd,
    output arp_pkg::t_stat o_stat,
    input  logic [31:0]   i_own_ipv4,
    input  logic [31:0]   i_timeout_ticks,
    input  logic [31:0]   i_refresh_ticks,
    input  logic [1:0]    i_req_type,
    input  logic [47:0]   i_now,
    input  logic [31:0]   i_ipv4_addr,
    input  logic [47:0]   i_mac_addr,
    input  logic [31:0]   i_target_ipv4,
    input  logic [15:0]   i_hw_type,
    input  logic [15:0]   i_proto_type,
    input  logic [7:0]    i_hw_size,
    input  logic [7:0]    i_proto_size,
    input  logic [15:0]   i_arp_opcode,
    input  logic [15:0]   i_frame_len,
    output logic [2:0]    o_status,
    output logic [47:0]   o_mac_out,
    output logic [31:0]   o_ipv4_out
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0] r_ent_ip    [TABLE_ENTRIES];
    logic [47:0] r_ent_hw    [TABLE_ENTRIES];
    logic [47:0] r_ent_stamp [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_refr;
    logic [TABLE_ENTRIES-1:0] r_fixed;

    logic [1:0]  r_type;
    logic [47:0] r_now;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic        r_hdr_ok;
    logic        r_op_req;
    logic        r_op_rep;
    logic [CW-1:0] r_ptr;
    logic        r_found, r_free_ok;
    logic [IW-1:0] r_found_idx, r_free_idx;

    logic [2:0]  r_status, n_status;
    logic [47:0] r_mac_out, n_mac_out;
    logic [31:0] r_ipv4_out, n_ipv4_out;

    // header checks, frame length need is fixed once the sizes are 6 and 4
    logic w_hdr_ok;
    assign w_hdr_ok = (i_hw_type == arp_pkg::HW_ETHERNET)
                   && (i_proto_type == arp_pkg::PROTO_IPV4)
                   && (i_hw_size == arp_pkg::HW_LEN)
                   && (i_proto_size == arp_pkg::PROTO_LEN)
                   && (i_frame_len >= arp_pkg::MIN_FRAME)
                   && (i_target_ipv4 == i_own_ipv4);

    logic [IW-1:0] w_pidx;
    assign w_pidx = r_ptr[IW-1:0];
    assign o_stat.scan_done = (r_ptr == LAST);

    // scan: one entry a cycle, first match and first free slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_type <= i_req_type;
            r_now <= i_now;
            r_ip <= i_ipv4_addr;
            r_mac <= i_mac_addr;
            r_hdr_ok <= w_hdr_ok;
            r_op_req <= (i_arp_opcode == arp_pkg::OP_REQUEST);
            r_op_rep <= (i_arp_opcode == arp_pkg::OP_REPLY);
            r_ptr <= '0;
            r_found <= 1'b0;
            r_free_ok <= 1'b0;
            r_found_idx <= '0;
            r_free_idx <= '0;
        end else if (i_cmd.step) begin
            if (r_valid[w_pidx] && r_ent_ip[w_pidx] == r_ip && !r_found) begin
                r_found <= 1'b1;
                r_found_idx <= w_pidx;
            end
            if (!r_valid[w_pidx] && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free_idx <= w_pidx;
            end
            if (r_ptr != LAST) r_ptr <= r_ptr + 1'b1;
        end
    end

    // age test on the matched entry, sums kept at 49 bits so no wrap
    logic [48:0] w_tmo_sum, w_ref_sum;
    logic        w_tmo, w_stale;
    assign w_tmo_sum = {1'b0, r_ent_stamp[r_found_idx]} + {17'd0, i_timeout_ticks};
    assign w_ref_sum = {1'b0, r_ent_stamp[r_found_idx]} + {17'd0, i_refresh_ticks};
    assign w_tmo = w_tmo_sum <= {1'b0, r_now};
    assign w_stale = w_ref_sum <= {1'b0, r_now};

    // static entries carry a zero stamp
    logic        w_fixed;
    logic [47:0] w_stamp;
    assign w_fixed = (r_type == arp_pkg::REQ_STATIC);
    assign w_stamp = w_fixed ? 48'd0 : r_now;

    logic w_bad_rx, w_rx_req;
    assign w_bad_rx = (r_type == arp_pkg::REQ_RX) && (!r_hdr_ok || !(r_op_req || r_op_rep));
    assign w_rx_req = (r_type == arp_pkg::REQ_RX) && r_op_req;

    // result and table update decision
    logic w_erase, w_mark_refr, w_update, w_insert;
    always_comb begin
        n_status = arp_pkg::ST_LEARNED;
        n_mac_out = '0;
        n_ipv4_out = r_ip;
        w_erase = 1'b0;
        w_mark_refr = 1'b0;
        w_update = 1'b0;
        w_insert = 1'b0;
        case (r_type)
            arp_pkg::REQ_LOOKUP: begin
                if (!r_found) begin
                    n_status = arp_pkg::ST_MISS;
                end else if (!r_fixed[r_found_idx] && w_tmo) begin
                    w_erase = 1'b1;
                    n_status = arp_pkg::ST_MISS;
                end else if (!r_fixed[r_found_idx] && w_stale && !r_refr[r_found_idx]) begin
                    w_mark_refr = 1'b1;
                    n_status = arp_pkg::ST_REFRESH;
                end else begin
                    n_status = arp_pkg::ST_HIT;
                    n_mac_out = r_ent_hw[r_found_idx];
                    n_ipv4_out = '0;
                end
            end
            arp_pkg::REQ_STATIC: begin
                if (r_found) begin
                    w_update = 1'b1;
                    n_mac_out = r_mac;
                end else if (r_free_ok) begin
                    w_insert = 1'b1;
                    n_mac_out = r_mac;
                end else begin
                    n_status = arp_pkg::ST_FULL;
                end
            end
            default: begin
                // learn, or a received packet
                if (w_bad_rx) begin
                    n_status = arp_pkg::ST_IGNORED;
                    n_ipv4_out = '0;
                end else if (w_rx_req) begin
                    n_status = arp_pkg::ST_REPLY;
                    n_mac_out = r_mac;
                end else if (r_found) begin
                    if (!r_fixed[r_found_idx]) begin
                        w_update = 1'b1;
                        n_mac_out = r_mac;
                    end else begin
                        n_mac_out = r_ent_hw[r_found_idx];
                    end
                end else if (r_free_ok) begin
                    w_insert = 1'b1;
                    n_mac_out = r_mac;
                end else begin
                    n_status = arp_pkg::ST_FULL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.finish) begin
            if (w_erase) r_valid[r_found_idx] <= 1'b0;
            if (w_mark_refr) r_refr[r_found_idx] <= 1'b1;
            if (w_update) begin
                r_ent_hw[r_found_idx] <= r_mac;
                r_ent_stamp[r_found_idx] <= w_stamp;
                r_refr[r_found_idx] <= 1'b0;
                r_fixed[r_found_idx] <= w_fixed;
            end
            if (w_insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_ent_ip[r_free_idx] <= r_ip;
                r_ent_hw[r_free_idx] <= r_mac;
                r_ent_stamp[r_free_idx] <= w_stamp;
                r_refr[r_free_idx] <= 1'b0;
                r_fixed[r_free_idx] <= w_fixed;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_mac_out <= n_mac_out;
            r_ipv4_out <= n_ipv4_out;
        end
    end

    assign o_status = r_status;
    assign o_mac_out = r_mac_out;
    assign o_ipv4_out = r_ipv4_out;
endmodule

/* rtl/core/arp_cache_and_responder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp cache and responder
// ipv4 over ethernet arp table with aging and received header classification
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance the table is scanned one
// entry per cycle to find the matching address and the first free slot, then
// the update is applied and the result is loaded into the output register.
// A new request is accepted while the previous result still waits in the
// output register; if that result is still there when the scan ends, the
// controller holds until it is taken. Configuration writes are always
// accepted.
module arp_cache_and_responder_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [47:0] i_now,
    input  logic [31:0] i_ipv4_addr,
    input  logic [47:0] i_mac_addr,
    input  logic [31:0] i_target_ipv4,
    input  logic [15:0] i_hw_type,
    input  logic [15:0] i_proto_type,
    input  logic [7:0]  i_hw_size,
    input  logic [7:0]  i_proto_size,
    input  logic [15:0] i_arp_opcode,
    input  logic [15:0] i_frame_len,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [47:0] o_mac_out,
    output logic [31:0] o_ipv4_out
);
    logic [31:0] r_own_ipv4, r_timeout, r_refresh;
    logic        r_out_valid;
    arp_pkg::t_cmd  w_cmd;
    arp_pkg::t_stat w_stat;
    logic w_in_ready;

    assign o_cfg_ready = 1'b1;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ipv4 <= '0;
            r_timeout <= 32'd65536;
            r_refresh <= 32'd32768;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                arp_pkg::CFG_OWN_IP:  r_own_ipv4 <= i_cfg_data;
                arp_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                arp_pkg::CFG_REFRESH: r_refresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register valid: set on load, cleared when the result is taken
    logic w_out_free;
    assign w_out_free = !r_out_valid || i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_cmd.finish) r_out_valid <= 1'b1;
        else if (i_ready) r_out_valid <= 1'b0;
    end
    assign o_valid = r_out_valid;
    assign o_ready = w_in_ready;

    arp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_fire (i_valid && w_in_ready),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    arp_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_own_ipv4      (r_own_ipv4),
        .i_timeout_ticks (r_timeout),
        .i_refresh_ticks (r_refresh),
        .i_req_type      (i_req_type),
        .i_now           (i_now),
        .i_ipv4_addr     (i_ipv4_addr),
        .i_mac_addr      (i_mac_addr),
        .i_target_ipv4   (i_target_ipv4),
        .i_hw_type       (i_hw_type),
        .i_proto_type    (i_proto_type),
        .i_hw_size       (i_hw_size),
        .i_proto_size    (i_proto_size),
        .i_arp_opcode    (i_arp_opcode),
        .i_frame_len     (i_frame_len),
        .o_status        (o_status),
        .o_mac_out       (o_mac_out),
        .o_ipv4_out      (o_ipv4_out)
    );
endmodule
